// ===== hdl/aspe_pkg.sv =====
// ----------------------------------------------------------------------------
// Angular spindle population encoder package
// Register codes, the configuration register set and fixed-point constants
// shared by the encoder datapath and its top level.
// ----------------------------------------------------------------------------
package aspe_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PEAK_CURRENT = 2'd0,
    CFG_FALL_RATE    = 2'd1,
    CFG_FIRST_CENTER = 2'd2,
    CFG_CENTER_STEP  = 2'd3
  } cfg_reg_e;

  // Configuration register set as seen by the datapath
  typedef struct packed {
    logic [15:0] peak_current;   // unsigned
    logic [15:0] fall_rate;      // unsigned Q8.8 per radian
    logic [15:0] first_center;   // signed Q3.12 radians
    logic [14:0] center_step;    // unsigned Q3.12 radians
  } cfg_regs_t;

  // log2(e) as Q1.15
  localparam logic [15:0] LOG2E_Q15 = 16'd47274;

  // Decay products at or above 2^27 always give a shift of 16 or more: zero
  localparam int unsigned X_KEEP_W = 27;
  localparam int unsigned Y_W      = 28;   // (x * log2e) >> 15

  // round(65536 * 2^(-k/16))
  function automatic logic [16:0] pow2_frac(input logic [3:0] k);
    logic [16:0] v;
    unique case (k)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd62757;
      4'd2:  v = 17'd60097;
      4'd3:  v = 17'd57549;
      4'd4:  v = 17'd55109;
      4'd5:  v = 17'd52773;
      4'd6:  v = 17'd50535;
      4'd7:  v = 17'd48393;
      4'd8:  v = 17'd46341;
      4'd9:  v = 17'd44376;
      4'd10: v = 17'd42495;
      4'd11: v = 17'd40693;
      4'd12: v = 17'd38968;
      4'd13: v = 17'd37316;
      4'd14: v = 17'd35734;
      4'd15: v = 17'd34219;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/aspe_expo.sv =====
// ----------------------------------------------------------------------------
// Spindle current pipeline
// Four register stages: distance, decay product, log2 split, peak scaling.
// Advances as one under a shared enable; valid bits travel with the data.
// ----------------------------------------------------------------------------
module aspe_expo #(
  parameter int IW = 3,
  parameter int CW = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  aspe_pkg::cfg_regs_t cfg,
  input  logic               tok_valid,
  input  logic [IW-1:0]      tok_idx,
  input  logic [CW-1:0]      tok_centre,
  input  logic [15:0]        tok_angle,
  output logic               res_valid,
  output logic [IW-1:0]      res_idx,
  output logic [15:0]        res_current
);
  import aspe_pkg::*;

  localparam int XW = CW + 16;

  // Stage 1: absolute distance from centre
  logic [CW:0]   diff;
  logic [CW-1:0] mag;
  logic          s1_valid_r;
  logic [IW-1:0] s1_idx_r;
  logic [CW-1:0] s1_dist_r;

  assign diff = {tok_centre[CW-1], tok_centre} - {{(CW-15){tok_angle[15]}}, tok_angle};
  // magnitude always fits CW bits
  assign mag  = diff[CW] ? (~diff[CW-1:0] + {{(CW-1){1'b0}}, 1'b1}) : diff[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r  <= tok_idx;
      s1_dist_r <= mag;
    end
  end

  // Stage 2: decay product, Q.20
  logic [XW-1:0] x_full;
  logic          s2_valid_r;
  logic [IW-1:0] s2_idx_r;
  logic [X_KEEP_W-1:0] s2_x_r;
  logic          s2_big_r;

  assign x_full = {{CW{1'b0}}, cfg.fall_rate} * {16'd0, s1_dist_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_idx_r <= s1_idx_r;
      s2_x_r   <= x_full[X_KEEP_W-1:0];
      s2_big_r <= |x_full[XW-1:X_KEEP_W];
    end
  end

  // Stage 3: scale by log2(e), split into shift and fraction index
  logic [X_KEEP_W+15:0] y_full;
  logic [Y_W-1:0]       y;
  logic          s3_valid_r;
  logic [IW-1:0] s3_idx_r;
  logic          s3_zero_r;
  logic [3:0]    s3_n_r;
  logic [3:0]    s3_k_r;

  assign y_full = {16'd0, s2_x_r} * {{X_KEEP_W{1'b0}}, LOG2E_Q15};
  assign y      = y_full[X_KEEP_W+15:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_idx_r  <= s2_idx_r;
      s3_zero_r <= s2_big_r | (|y[Y_W-1:24]);
      s3_n_r    <= y[23:20];
      s3_k_r    <= y[19:16];
    end
  end

  // Stage 4: peak current times fractional power of two
  logic [31:0]   prod;
  logic          s4_valid_r;
  logic [IW-1:0] s4_idx_r;
  logic          s4_zero_r;
  logic [3:0]    s4_n_r;
  logic [31:0]   s4_prod_r;

  assign prod = {16'd0, cfg.peak_current} * {15'd0, pow2_frac(s3_k_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_idx_r  <= s3_idx_r;
      s4_zero_r <= s3_zero_r;
      s4_n_r    <= s3_n_r;
      s4_prod_r <= prod;
    end
  end

  // Final shift; product never reaches 2^32 so bits 31:16 hold it all
  logic [15:0] scaled;
  assign scaled = s4_prod_r[31:16] >> s4_n_r;

  assign res_valid   = s4_valid_r;
  assign res_idx     = s4_idx_r;
  assign res_current = s4_zero_r ? 16'd0 : scaled;

endmodule

// ===== hdl/angular_spindle_population_encoder.sv =====
// ----------------------------------------------------------------------------
// Angular spindle population encoder
// One joint angle in, one exponentially decaying current per spindle out.
// ----------------------------------------------------------------------------
// The first result passes the issue registers, the four datapath stages and the output register.
// One spindle result a cycle while the result channel does not stall, set by
// the issue counter that walks the spindle centres.
// The next angle is taken as the last spindle of the current one issues.
// Reset: synchronous active-low; zeroes config and issue counter, empties pipeline.
module angular_spindle_population_encoder #(
  parameter int SPINDLES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_joint_angle,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_receptor_index,
  output logic [15:0] out_receptor_current,
  output logic        out_last_receptor
);
  import aspe_pkg::*;

  localparam int IW = (SPINDLES > 1) ? $clog2(SPINDLES) : 1;
  localparam int CW = 17 + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(SPINDLES - 1);

  // Configuration registers
  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_PEAK_CURRENT: cfg_r.peak_current <= cfg_wdata;
        CFG_FALL_RATE:    cfg_r.fall_rate    <= cfg_wdata;
        CFG_FIRST_CENTER: cfg_r.first_center <= cfg_wdata;
        CFG_CENTER_STEP:  cfg_r.center_step  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: blocked only by a held result
  logic adv;
  logic out_valid_r;
  assign adv = !(out_valid_r && out_stall);

  // Issue stage: walks spindle centres, one per cycle while the pipeline advances
  logic          busy_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] centre_r;
  logic [15:0]   angle_r;
  logic          in_acc;
  logic          on_last;

  assign on_last  = (idx_r == LAST_IDX);
  assign in_stall = !adv || (busy_r && !on_last);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (adv && busy_r) begin
      busy_r <= !on_last;
      idx_r  <= on_last ? '0 : idx_r + {{(IW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      centre_r <= {{(CW-16){cfg_r.first_center[15]}}, cfg_r.first_center};
      angle_r  <= in_joint_angle;
    end else if (adv && busy_r) begin
      centre_r <= centre_r + {{(CW-15){1'b0}}, cfg_r.center_step};
    end
  end

  // Current datapath
  logic          res_valid;
  logic [IW-1:0] res_idx;
  logic [15:0]   res_current;

  aspe_expo #(
    .IW (IW),
    .CW (CW)
  ) u_expo (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (cfg_r),
    .tok_valid   (busy_r),
    .tok_idx     (idx_r),
    .tok_centre  (centre_r),
    .tok_angle   (angle_r),
    .res_valid   (res_valid),
    .res_idx     (res_idx),
    .res_current (res_current)
  );

  // Output register
  logic [IW+2:0] idx_ext;
  logic [2:0]    index_r;
  logic [15:0]   current_r;
  logic          last_r;

  assign idx_ext = {3'b000, res_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      index_r   <= idx_ext[2:0];
      current_r <= res_current;
      last_r    <= (res_idx == LAST_IDX);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_receptor_index   = index_r;
  assign out_receptor_current = current_r;
  assign out_last_receptor    = last_r;

  // Checks
  logic [IW+2:0] last_ext;
  assign last_ext = {3'b000, LAST_IDX};

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> index_r == last_ext[2:0])
    else $error("last marker on wrong spindle index");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && idx_r == '0)
    else $error("accepted angle did not start at spindle zero");

  a_issue_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && adv && on_last |=> !busy_r || idx_r == '0)
    else $error("issue counter ran past last spindle");

endmodule

// ===== test/angular_spindle_population_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// Angular spindle population encoder testbench
// Sends joint angles through the encoder under several register settings and
// checks every spindle current against a fixed-point predictor kept in step
// with the register writes. Both channels idle and stall at random; one phase
// holds the result channel off long enough to back the block up.
// ----------------------------------------------------------------------------
module angular_spindle_population_encoder_tb;
  import aspe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPINDLES = 8;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam longint unsigned LOG2E_FIX = 47274;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] current;
    logic        last;
  } receptor_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PEAK_CURRENT;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_joint_angle = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_receptor_index;
  logic [15:0] out_receptor_current;
  logic        out_last_receptor;

  // Register copy for the predictor (reset values)
  logic [15:0] cfg_peak = 16'd0;
  logic [15:0] cfg_decay = 16'd0;
  logic [15:0] cfg_first = 16'd0;
  logic [14:0] cfg_step = 15'd0;

  receptor_result_t expected_currents[$];
  int unsigned      failures = 0;
  bit               idling_on = 1'b1;
  bit               result_taken = 1'b0;
  logic             rx_holding = 1'b0;
  int unsigned      rx_left = 0;
  event             hold_go;

  angular_spindle_population_encoder #(.SPINDLES(SPINDLES)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_joint_angle       (in_joint_angle),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_receptor_index   (out_receptor_index),
    .out_receptor_current (out_receptor_current),
    .out_last_receptor    (out_last_receptor)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // 2^(-k/16) in Q16, rounded
  function automatic logic [16:0] exp2_fraction(input logic [3:0] k);
    case (k)
      4'd0:    return 17'd65536;
      4'd1:    return 17'd62757;
      4'd2:    return 17'd60097;
      4'd3:    return 17'd57549;
      4'd4:    return 17'd55109;
      4'd5:    return 17'd52773;
      4'd6:    return 17'd50535;
      4'd7:    return 17'd48393;
      4'd8:    return 17'd46341;
      4'd9:    return 17'd44376;
      4'd10:   return 17'd42495;
      4'd11:   return 17'd40693;
      4'd12:   return 17'd38968;
      4'd13:   return 17'd37316;
      4'd14:   return 17'd35734;
      default: return 17'd34219;
    endcase
  endfunction

  // peak * 2^(-decay*span*log2e), shift for the integer part, table for the fraction
  function automatic logic [15:0] expected_current(input int unsigned idx,
                                                   input logic [15:0] angle);
    longint          centre;
    longint          diff;
    longint unsigned span;
    longint unsigned scaled;
    longint unsigned log2_scaled;
    longint unsigned whole;
    longint unsigned prod;
    logic [3:0]      frac_idx;
    centre = longint'($signed(cfg_first)) + longint'(idx) * longint'(cfg_step);
    diff = centre - longint'($signed(angle));
    span = (diff < 0) ? -diff : diff;
    scaled = span * 64'(cfg_decay);
    log2_scaled = (scaled * LOG2E_FIX) >> 15;
    whole = log2_scaled >> 20;
    frac_idx = log2_scaled[19:16];
    // far from the centre: shift out of range, current is zero
    if (whole > 40)
      return 16'd0;
    prod = 64'(cfg_peak) * 64'(exp2_fraction(frac_idx));
    return 16'(prod >> (16 + whole));
  endfunction

  function automatic void predict_currents(input logic [15:0] angle);
    receptor_result_t r;
    for (int i = 0; i < SPINDLES; i++) begin
      r.index = 3'(i);
      r.current = expected_current(i, angle);
      r.last = (i == SPINDLES - 1);
      expected_currents.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    if (!idling_on || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  // Mostly angles around some spindle centre, the rest anywhere
  function automatic logic [15:0] pick_angle();
    int a;
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom);
    a = int'($signed(cfg_first))
        + int'($urandom_range(0, SPINDLES - 1)) * int'(cfg_step)
        + int'($urandom_range(0, 8192)) - 4096;
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    return a[15:0];
  endfunction

  task automatic write_reg(input cfg_reg_e sel, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    case (sel)
      CFG_PEAK_CURRENT: cfg_peak = value;
      CFG_FALL_RATE:    cfg_decay = value;
      CFG_FIRST_CENTER: cfg_first = value;
      CFG_CENTER_STEP:  cfg_step = value[14:0];
      default: ;
    endcase
  endtask

  // Only called with the block idle
  task automatic set_config(input logic [15:0] peak, input logic [15:0] decay,
                            input logic [15:0] first, input logic [15:0] step);
    write_reg(CFG_PEAK_CURRENT, peak);
    write_reg(CFG_FALL_RATE, decay);
    write_reg(CFG_FIRST_CENTER, first);
    write_reg(CFG_CENTER_STEP, step);
    cfg_we <= 1'b0;
  endtask

  // One angle transaction; valid is left high for a back-to-back follower
  task automatic send_angle(input logic [15:0] angle);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_angle <= angle;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predict_currents(angle);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_currents.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver stall: random wait after each transaction, forced during a hold
  always @(posedge clk) begin
    if (result_taken)
      rx_left = pick_gap();
    else if (rx_left != 0)
      rx_left = rx_left - 1;
    out_stall <= rx_holding || (rx_left != 0);
  end

  // Long hold-off, counted here so the sender keeps going meanwhile
  initial begin
    forever begin
      @(hold_go);
      rx_holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_holding <= 1'b0;
    end
  end

  // Checker: sampled mid-cycle, ahead of the edge that moves the transaction
  always @(negedge clk) begin : result_check
    receptor_result_t got;
    receptor_result_t want;
    result_taken = rst_n && out_valid && !out_stall;
    if (result_taken) begin
      got = {out_receptor_index, out_receptor_current, out_last_receptor};
      if (expected_currents.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: index %0d current %0d last %0d",
                   got.index, got.current, got.last);
      end else begin
        want = expected_currents.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected index %0d current %0d last %0d, got %0d %0d %0d",
                     want.index, want.current, want.last,
                     got.index, got.current, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers straight out of reset: zero peak gives zero everywhere
  task automatic test_reset_defaults();
    send_angle(16'h0000);
    send_angle(16'h7FFF);
    send_angle(16'h8000);
    drain_results();
  endtask

  // Angles on, between and far from the centres, 1 rad spacing
  task automatic test_centre_response();
    set_config(16'd40000, 16'h0300, 16'hC800, 16'h1000);
    send_angle(16'hC800);
    send_angle(16'h3800);
    send_angle(16'hD000);
    send_angle(16'h0000);
    send_angle(16'h0001);
    send_angle(16'hFFFF);
    send_angle(16'h8000);
    send_angle(16'h7FFF);
    drain_results();
  endtask

  // Zero decay gives peak everywhere; zero step gives one current for all
  task automatic test_flat_response();
    set_config(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
    send_angle(16'h7FFF);
    send_angle(16'h8000);
    drain_results();
    set_config(16'd30000, 16'h0180, 16'd1000, 16'h0000);
    send_angle(16'd1000);
    send_angle(16'h9C40);
    drain_results();
  endtask

  // Steepest decay, widest spacing: distant spindles cut off to zero
  task automatic test_distance_cutoff();
    set_config(16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_angle(16'h8000);
    send_angle(16'h8001);
    send_angle(16'h0000);
    send_angle(16'h7FFF);
    drain_results();
  endtask

  // Receiver holds off while angles keep coming, so the input stalls
  task automatic test_backpressure();
    set_config(16'd52000, 16'h0200, 16'hE000, 16'h0800);
    idling_on <= 1'b0;
    -> hold_go;
    repeat (40) send_angle(pick_angle());
    drain_results();
    idling_on <= 1'b1;
  endtask

  // Random register settings, one phase with no idling on either side
  task automatic test_random_sweep();
    logic [15:0] peak;
    logic [15:0] decay;
    logic [15:0] first;
    logic [15:0] step;
    for (int p = 0; p < 6; p++) begin
      idling_on <= (p != 2);
      peak = 16'($urandom);
      case ($urandom_range(0, 3))
        0:       decay = 16'($urandom);
        1:       decay = 16'($urandom_range(0, 255));
        default: decay = 16'($urandom_range(0, 2047));
      endcase
      if ($urandom_range(0, 2) == 0)
        first = 16'($urandom);
      else
        first = 16'(-int'($urandom_range(0, 24000)));
      if ($urandom_range(0, 2) == 0)
        step = 16'($urandom);
      else
        step = {1'($urandom), 15'($urandom_range(0, 6000))};
      set_config(peak, decay, first, step);
      repeat (80) send_angle(pick_angle());
      drain_results();
    end
    idling_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_centre_response();
    test_flat_response();
    test_distance_cutoff();
    test_backpressure();
    test_random_sweep();
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
